### rtl/mqmb_pkg.sv
// Shared codes, widths and handshake structs of the message mailbox.
package mqmb_pkg;

  localparam int OP_W       = 3;
  localparam int ID_W       = 8;
  localparam int ST_W       = 2;
  localparam int CNT_OUT_W  = 5;
  localparam int MSG_PORT_W = 64;

  localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
  localparam logic [OP_W-1:0] OP_DESTROY = 3'd1;
  localparam logic [OP_W-1:0] OP_SEND    = 3'd2;
  localparam logic [OP_W-1:0] OP_RECEIVE = 3'd3;
  localparam logic [OP_W-1:0] OP_COUNT   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_NO_SLOT   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;       // capture the input beat, start the queue record read
    logic            create;     // make a new queue
    logic            destroy;    // kill the addressed queue
    logic            push;       // append the held message
    logic            pop;        // advance the read pointer, read the message store
    logic            finish;     // register the result beat
    logic            put_id;     // result carries the new queue number
    logic            put_msg;    // result carries the popped message
    logic            put_count;  // result carries the occupancy
    logic [ST_W-1:0] status;
  } mqmb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            id_ok;      // queue number names a live queue
    logic            full;
    logic            empty;
    logic            bank_full;  // every queue number has been handed out
  } mqmb_stat_t;

endpackage

### rtl/mqmb_ram.sv
// Generic simple dual-port RAM with registered read.
module mqmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/mqmb_ctrl.sv
// Operation sequencer of the message mailbox.
module mqmb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mqmb_pkg::mqmb_stat_t stat,
  output mqmb_pkg::mqmb_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_RDMSG = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status = mqmb_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
        unique case (stat.op)
          mqmb_pkg::OP_CREATE: begin
            if (stat.bank_full) begin
              cmd.status = mqmb_pkg::ST_NO_SLOT;
            end else begin
              cmd.create = 1'b1;
              cmd.put_id = 1'b1;
            end
          end
          mqmb_pkg::OP_DESTROY: begin
            if (!stat.id_ok) begin
              cmd.status = mqmb_pkg::ST_NOT_FOUND;
            end else begin
              cmd.destroy = 1'b1;
            end
          end
          mqmb_pkg::OP_SEND: begin
            if (!stat.id_ok) begin
              cmd.status = mqmb_pkg::ST_NOT_FOUND;
            end else if (stat.full) begin
              cmd.status = mqmb_pkg::ST_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
          mqmb_pkg::OP_RECEIVE: begin
            if (!stat.id_ok || stat.empty) begin
              cmd.status = mqmb_pkg::ST_NOT_FOUND;
            end else begin
              // The payload comes out of the store in the following state, S_RDMSG.
              cmd.pop    = 1'b1;
              cmd.finish = 1'b0;
              state_nxt  = S_RDMSG;
            end
          end
          mqmb_pkg::OP_COUNT: begin
            if (!stat.id_ok) begin
              cmd.status = mqmb_pkg::ST_NOT_FOUND;
            end else begin
              cmd.put_count = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_RDMSG: begin
        cmd.finish  = 1'b1;
        cmd.put_msg = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/mqmb_dp.sv
// Datapath of the message mailbox: queue records, message store and result registers.
module mqmb_dp #(
  parameter int NUM_QUEUES  = 128,
  parameter int QUEUE_DEPTH = 16,
  parameter int MSG_WIDTH   = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [mqmb_pkg::OP_W-1:0]            in_operation,
  input  logic [mqmb_pkg::ID_W-1:0]            in_queue_id,
  input  logic [mqmb_pkg::MSG_PORT_W-1:0]      in_message_in,
  input  mqmb_pkg::mqmb_cmd_t                  cmd,
  output mqmb_pkg::mqmb_stat_t                 stat,
  output logic                                 out_valid,
  output logic [mqmb_pkg::ST_W-1:0]            out_status,
  output logic [mqmb_pkg::ID_W-1:0]            out_created_id,
  output logic [mqmb_pkg::MSG_PORT_W-1:0]      out_message_out,
  output logic [mqmb_pkg::CNT_OUT_W-1:0]       out_message_count
);

  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int MW    = 2 * PW + CW;
  localparam int SDEP  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int SAW   = $clog2(SDEP);
  localparam int PORTW = mqmb_pkg::MSG_PORT_W;
  localparam int IDW   = mqmb_pkg::ID_W;
  localparam int COW   = mqmb_pkg::CNT_OUT_W;

  logic [mqmb_pkg::OP_W-1:0] op_r;
  logic [IDW-1:0]            id_r;
  logic [QW-1:0]             qidx_r;
  logic [MSG_WIDTH-1:0]      msg_r;
  logic [IDW-1:0]            made_r;
  logic [NUM_QUEUES-1:0]     alive_r;

  // Queue record: read pointer, write pointer, occupancy.
  logic [MW-1:0] meta_rdata, meta_wdata;
  logic [QW-1:0] meta_waddr;
  logic          meta_we;
  logic [PW-1:0] rd_ptr, wr_ptr, rd_ptr_nxt, wr_ptr_nxt;
  logic [CW-1:0] occ;

  logic [SAW-1:0]       store_base, store_waddr, store_raddr;
  logic [MSG_WIDTH-1:0] store_rdata;
  logic [IDW-1:0]       made_inc;

  assign rd_ptr = meta_rdata[MW-1 -: PW];
  assign wr_ptr = meta_rdata[CW +: PW];
  assign occ    = meta_rdata[CW-1:0];

  assign rd_ptr_nxt = (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  assign wr_ptr_nxt = (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign made_inc   = made_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      id_r   <= in_queue_id;
      qidx_r <= QW'(in_queue_id - 1'b1);
      msg_r  <= in_message_in[MSG_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      made_r  <= '0;
      alive_r <= '0;
    end else begin
      if (cmd.create) begin
        made_r                <= made_inc;
        alive_r[QW'(made_r)]  <= 1'b1;
      end
      if (cmd.destroy) begin
        alive_r[qidx_r] <= 1'b0;
      end
    end
  end

  assign stat.op        = op_r;
  assign stat.id_ok     = (id_r != '0) && (id_r <= made_r) && alive_r[qidx_r];
  assign stat.full      = (occ >= CW'(QUEUE_DEPTH));
  assign stat.empty     = (occ == '0);
  assign stat.bank_full = (made_r >= IDW'(NUM_QUEUES));

  // A new queue starts with both pointers and its occupancy at zero.
  always_comb begin
    meta_we    = cmd.create | cmd.push | cmd.pop;
    meta_waddr = qidx_r;
    meta_wdata = {rd_ptr, wr_ptr, occ};
    priority if (cmd.create) begin
      meta_waddr = QW'(made_r);
      meta_wdata = '0;
    end else if (cmd.push) begin
      meta_wdata = {rd_ptr, wr_ptr_nxt, occ + 1'b1};
    end else if (cmd.pop) begin
      meta_wdata = {rd_ptr_nxt, wr_ptr, occ - 1'b1};
    end else begin
      meta_wdata = {rd_ptr, wr_ptr, occ};
    end
  end

  mqmb_ram #(
    .WIDTH (MW),
    .DEPTH (NUM_QUEUES)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_we),
    .wr_addr (meta_waddr),
    .wr_data (meta_wdata),
    .rd_en   (cmd.load),
    .rd_addr (QW'(in_queue_id - 1'b1)),
    .rd_data (meta_rdata)
  );

  assign store_base  = SAW'(qidx_r) * SAW'(QUEUE_DEPTH);
  assign store_waddr = store_base + SAW'(wr_ptr);
  assign store_raddr = store_base + SAW'(rd_ptr);

  mqmb_ram #(
    .WIDTH (MSG_WIDTH),
    .DEPTH (SDEP)
  ) u_store_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (store_waddr),
    .wr_data (msg_r),
    .rd_en   (cmd.pop),
    .rd_addr (store_raddr),
    .rd_data (store_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status        <= cmd.status;
      out_created_id    <= cmd.put_id ? made_inc : '0;
      out_message_out   <= cmd.put_msg ? PORTW'(store_rdata) : '0;
      out_message_count <= cmd.put_count ? COW'(occ) : '0;
    end
  end

endmodule

### rtl/multi_queue_message_mailbox.sv
// Top level of the multi-queue message mailbox.
// out_valid is registered from the sequencer's execute state, or from its message read state
// for a popping receive. No new operation is taken while busy, which covers the queue
// record read-modify-write and the message store read, each through a registered RAM port.
// Reset clears the queue counter, the live flags and the sequencer; the RAMs need no clearing.
// Results are shown for one cycle on out_valid; the receiver cannot stall them.
module multi_queue_message_mailbox #(
  parameter int NUM_QUEUES  = 128,
  parameter int QUEUE_DEPTH = 16,
  parameter int MSG_WIDTH   = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [mqmb_pkg::OP_W-1:0]            in_operation,
  input  logic [mqmb_pkg::ID_W-1:0]            in_queue_id,
  input  logic [mqmb_pkg::MSG_PORT_W-1:0]      in_message_in,
  output logic                                 out_valid,
  output logic [mqmb_pkg::ST_W-1:0]            out_status,
  output logic [mqmb_pkg::ID_W-1:0]            out_created_id,
  output logic [mqmb_pkg::MSG_PORT_W-1:0]      out_message_out,
  output logic [mqmb_pkg::CNT_OUT_W-1:0]       out_message_count
);

  mqmb_pkg::mqmb_cmd_t  cmd;
  mqmb_pkg::mqmb_stat_t stat;

  mqmb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  mqmb_dp #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MSG_WIDTH   (MSG_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_operation      (in_operation),
    .in_queue_id       (in_queue_id),
    .in_message_in     (in_message_in),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_created_id    (out_created_id),
    .out_message_out   (out_message_out),
    .out_message_count (out_message_count)
  );

endmodule

### tb/multi_queue_message_mailbox_tb.sv
// Self-checking testbench for the multi-queue message mailbox.
`timescale 1ns / 100ps

module multi_queue_message_mailbox_tb;

  localparam int NQ           = 128;
  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1125;
  localparam int STALL_LIMIT  = 1000;
  localparam int MAX_REPORTS  = 10;
  localparam int OPW          = mqmb_pkg::OP_W;
  localparam int IDW          = mqmb_pkg::ID_W;
  localparam int STW          = mqmb_pkg::ST_W;
  localparam int MSGW         = mqmb_pkg::MSG_PORT_W;
  localparam int CNTW         = mqmb_pkg::CNT_OUT_W;

  typedef struct {
    logic [STW-1:0]  status;
    logic [IDW-1:0]  created_id;
    logic [MSGW-1:0] message_out;
    logic [CNTW-1:0] message_count;
  } mbox_reply_t;

  // Tracks the queue bank and holds the replies still owed by the block.
  class mbox_scoreboard;
    int made_count;
    bit alive[NQ];
    int rd_slot[NQ];
    int wr_slot[NQ];
    int fill[NQ];
    logic [MSGW-1:0] slots[NQ][DEPTH];
    mbox_reply_t pending_replies[$];
    int fail_count;

    function void note_op(logic [OPW-1:0] op, logic [IDW-1:0] id,
                          logic [MSGW-1:0] msg);
      mbox_reply_t r;
      int q;
      r = '{default: '0};
      q = -1;
      if (id != 0 && id <= made_count && alive[id - 1]) q = id - 1;
      case (op)
        mqmb_pkg::OP_CREATE: begin
          if (made_count >= NQ) begin
            r.status = mqmb_pkg::ST_NO_SLOT;
          end else begin
            q = made_count;
            made_count++;
            alive[q]   = 1'b1;
            rd_slot[q] = 0;
            wr_slot[q] = 0;
            fill[q]    = 0;
            r.created_id = IDW'(made_count);
          end
        end
        mqmb_pkg::OP_DESTROY: begin
          if (q < 0) begin
            r.status = mqmb_pkg::ST_NOT_FOUND;
          end else begin
            alive[q] = 1'b0;
            fill[q]  = 0;
          end
        end
        mqmb_pkg::OP_SEND: begin
          if (q < 0) begin
            r.status = mqmb_pkg::ST_NOT_FOUND;
          end else if (fill[q] >= DEPTH) begin
            r.status = mqmb_pkg::ST_FULL;
          end else begin
            slots[q][wr_slot[q]] = msg;
            wr_slot[q] = (wr_slot[q] + 1 >= DEPTH) ? 0 : wr_slot[q] + 1;
            fill[q]++;
          end
        end
        mqmb_pkg::OP_RECEIVE: begin
          if (q < 0 || fill[q] == 0) begin
            r.status = mqmb_pkg::ST_NOT_FOUND;
          end else begin
            r.message_out = slots[q][rd_slot[q]];
            rd_slot[q] = (rd_slot[q] + 1 >= DEPTH) ? 0 : rd_slot[q] + 1;
            fill[q]--;
          end
        end
        mqmb_pkg::OP_COUNT: begin
          if (q < 0) r.status = mqmb_pkg::ST_NOT_FOUND;
          else r.message_count = CNTW'(fill[q]);
        end
        default: begin
        end
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_reply(mbox_reply_t got);
      mbox_reply_t want;
      if (pending_replies.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result beat with no operation outstanding", $realtime);
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status || got.created_id !== want.created_id ||
          got.message_out !== want.message_out ||
          got.message_count !== want.message_count) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display({"%0t: mismatch exp st=%0d id=%0d msg=%h cnt=%0d",
                    " got st=%0d id=%0d msg=%h cnt=%0d"},
                   $realtime, want.status, want.created_id, want.message_out,
                   want.message_count, got.status, got.created_id, got.message_out,
                   got.message_count);
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic [OPW-1:0]  in_operation = '0;
  logic [IDW-1:0]  in_queue_id = '0;
  logic [MSGW-1:0] in_message_in = '0;
  logic            out_valid;
  logic [STW-1:0]  out_status;
  logic [IDW-1:0]  out_created_id;
  logic [MSGW-1:0] out_message_out;
  logic [CNTW-1:0] out_message_count;

  mbox_scoreboard sb = new();
  int  items_done = 0;
  bit  idle_on = 1'b1;
  int  stall_cycles = 0;

  multi_queue_message_mailbox dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_queue_id       (in_queue_id),
    .in_message_in     (in_message_in),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_created_id    (out_created_id),
    .out_message_out   (out_message_out),
    .out_message_count (out_message_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    mbox_reply_t got;
    if (rst_n && out_valid) begin
      got.status        = out_status;
      got.created_id    = out_created_id;
      got.message_out   = out_message_out;
      got.message_count = out_message_count;
      sb.check_reply(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mostly recently created queues, so that sequences on one queue reach full and empty.
  function automatic logic [IDW-1:0] pick_target();
    int r;
    int lo;
    r = $urandom_range(0, 99);
    if (sb.made_count == 0 || r >= 85) return IDW'($urandom_range(0, 255));
    if (r < 60) begin
      lo = (sb.made_count > 4) ? sb.made_count - 3 : 1;
      return IDW'($urandom_range(lo, sb.made_count));
    end
    return IDW'($urandom_range(1, sb.made_count));
  endfunction

  function automatic logic [MSGW-1:0] rand_msg();
    return {$urandom(), $urandom()};
  endfunction

  // Holds start until the beat is taken, then notes it and may idle for a while.
  task automatic issue_op(logic [OPW-1:0] op, logic [IDW-1:0] id,
                          logic [MSGW-1:0] msg);
    int gap;
    start         <= 1'b1;
    in_operation  <= op;
    in_queue_id   <= id;
    in_message_in <= msg;
    do @(posedge clk); while (busy);
    sb.note_op(op, id, msg);
    if (op <= mqmb_pkg::OP_COUNT) items_done++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_burst(logic [IDW-1:0] id);
    int mode;
    int len;
    int r;
    mode = $urandom_range(0, 2);
    len  = (mode == 2) ? $urandom_range(1, 12) : $urandom_range(4, 20);
    repeat (len) begin
      if (mode == 0) begin
        issue_op(mqmb_pkg::OP_SEND, id, rand_msg());
      end else if (mode == 1) begin
        issue_op(mqmb_pkg::OP_RECEIVE, id, rand_msg());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) issue_op(mqmb_pkg::OP_SEND, id, rand_msg());
        else if (r < 75) issue_op(mqmb_pkg::OP_RECEIVE, id, rand_msg());
        else if (r < 92) issue_op(mqmb_pkg::OP_COUNT, id, rand_msg());
        else if (r < 95) issue_op(mqmb_pkg::OP_DESTROY, id, rand_msg());
        else issue_op(OPW'($urandom_range(5, 7)), id, rand_msg());
      end
    end
  endtask

  initial begin
    int r;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unknown queue numbers before anything exists.
    issue_op(mqmb_pkg::OP_RECEIVE, 8'd0, '1);
    issue_op(mqmb_pkg::OP_COUNT, 8'd0, '0);
    issue_op(mqmb_pkg::OP_SEND, 8'd0, '1);
    issue_op(mqmb_pkg::OP_DESTROY, 8'd0, '0);
    // A fresh queue is empty.
    issue_op(mqmb_pkg::OP_CREATE, 8'd0, '0);
    issue_op(mqmb_pkg::OP_COUNT, 8'd1, '0);
    issue_op(mqmb_pkg::OP_RECEIVE, 8'd1, '0);
    // Payload extremes pass through in order.
    issue_op(mqmb_pkg::OP_SEND, 8'd1, '1);
    issue_op(mqmb_pkg::OP_SEND, 8'd1, '0);
    issue_op(mqmb_pkg::OP_COUNT, 8'd1, '0);
    issue_op(mqmb_pkg::OP_RECEIVE, 8'd1, '0);
    issue_op(mqmb_pkg::OP_RECEIVE, 8'd1, '1);
    // A destroyed queue is gone for good.
    issue_op(mqmb_pkg::OP_DESTROY, 8'd1, '0);
    issue_op(mqmb_pkg::OP_SEND, 8'd1, '1);
    issue_op(mqmb_pkg::OP_DESTROY, 8'd1, '0);
    issue_op(mqmb_pkg::OP_COUNT, 8'd1, '0);
    // Numbers above the created count and the highest queue number.
    issue_op(mqmb_pkg::OP_CREATE, 8'hff, '1);
    issue_op(mqmb_pkg::OP_SEND, 8'hff, '1);
    issue_op(mqmb_pkg::OP_COUNT, 8'd3, '0);
    // Undefined operation codes.
    issue_op(3'd5, 8'd2, '1);
    issue_op(3'd6, 8'd2, '1);
    issue_op(3'd7, 8'd2, '1);

    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) idle_on = !idle_on;
      r = $urandom_range(0, 99);
      // Creates come often enough that the bank runs out late in the run.
      if (r < 35) repeat ($urandom_range(1, 3))
        issue_op(mqmb_pkg::OP_CREATE, IDW'($urandom_range(0, 255)), rand_msg());
      else if (r < 40) issue_op(mqmb_pkg::OP_DESTROY, pick_target(), rand_msg());
      else run_burst(pick_target());
    end
    start <= 1'b0;

    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/mqmb_pkg.sv
rtl/mqmb_ram.sv
rtl/mqmb_ctrl.sv
rtl/mqmb_dp.sv
rtl/multi_queue_message_mailbox.sv
tb/multi_queue_message_mailbox_tb.sv
